>>> hw/rtl/laplacian_edge_stencil_3x3_macros.svh
// assertion macros used by the laplacian edge filter checker
`ifndef LAPLACIAN_EDGE_STENCIL_3X3_MACROS_SVH
`define LAPLACIAN_EDGE_STENCIL_3X3_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LES_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/lapedge_pkg.sv
// types and constants of the laplacian edge filter
package lapedge_pkg;

	localparam int PIX_W       = 8;
	localparam int CFG_W       = 11;
	localparam int MIN_WIDTH   = 3;
	localparam int WIDTH_RESET = 1024;
	localparam int FIRST_COL   = 2;
	localparam int PIX_MAX     = 255;

	localparam logic [1:0] ROW_FULL = 2'd2;

	typedef logic [PIX_W-1:0] pix_t;

	// one line memory word: row before last and last row at one column
	typedef struct packed {
		pix_t top;
		pix_t mid;
	} lb_pair_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} lb_ctl_t;

endpackage

>>> hw/rtl/lapedge_linebuf.sv
// two-row line memory with registered read and write-to-read forwarding
module lapedge_linebuf #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lapedge_pkg::lb_ctl_t  ctl,
	input  logic [ADDR_W-1:0]     rd_addr,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  lapedge_pkg::lb_pair_t wr_data,
	output lapedge_pkg::lb_pair_t rd_data
);
	import lapedge_pkg::*;

	lb_pair_t mem [DEPTH];
	lb_pair_t rd_q;
	lb_pair_t fwd_data_q;
	logic     fwd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// a read of the entry being written in the same cycle takes the new word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (ctl.rd_en) begin
			fwd_q <= ctl.wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule

>>> hw/rtl/laplacian_edge_stencil_3x3.sv
// 3x3 laplacian edge filter: raster pixel stream in, clamped response out
// a result is registered at the output after the pixel completing its window passes stage 1
// one pixel per clock unless stalled; line memory read at transfer, written as stage 1 retires
// a held result stalls the input only when the next pixel also makes a result
// reset clears counters, window and output valid; image width returns to min(1024, MAX_WIDTH)
// the line memory is not cleared; in a frame, entries feeding a result are written first
module laplacian_edge_stencil_3x3 #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lapedge_pkg::CFG_W-1:0] image_width,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  lapedge_pkg::pix_t             pixel,
	input  logic                          frame_start,
	output logic                          res_valid,
	input  logic                          res_stall,
	output lapedge_pkg::pix_t             edge_value,
	output logic                          row_end
);
	import lapedge_pkg::*;

	localparam int COL_W   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
	localparam int CMP_W   = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
	localparam int RST_EFF = (MAX_WIDTH < WIDTH_RESET) ? MAX_WIDTH : WIDTH_RESET;
	localparam logic [COL_W-1:0] RST_LAST = COL_W'(RST_EFF - 1);
	localparam logic [COL_W-1:0] MAX_LAST = COL_W'(MAX_WIDTH - 1);

	logic [COL_W-1:0] last_col_q;
	logic [COL_W-1:0] column_count_q;
	logic [1:0]       row_count_q;
	logic [CMP_W-1:0] width_ext;

	// front of the pipe
	logic             accept;
	logic [COL_W-1:0] cc;
	logic [1:0]       rc;
	logic [COL_W-1:0] col;
	logic             row_done;
	logic             produce;

	// stage 1: line memory data returns, window and write-back
	logic             valid_s1;
	pix_t             px_s1;
	logic [COL_W-1:0] col_s1;
	logic             produce_s1;
	logic             row_end_s1;
	logic             retire_s1;
	logic             out_free;

	lb_ctl_t  lb_ctl;
	lb_pair_t lb_rd;
	lb_pair_t lb_wr;

	pix_t win_q [6];

	logic [10:0]        nb_sum;
	logic [10:0]        centre8;
	logic signed [11:0] diff;
	pix_t               clamped;

	logic res_valid_q;
	pix_t edge_value_q;
	logic row_end_q;

	assign cfg_ready = 1'b1;
	assign width_ext = CMP_W'(image_width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= RST_LAST;
		end else if (cfg_valid) begin
			if (width_ext < CMP_W'(MIN_WIDTH)) begin
				last_col_q <= COL_W'(MIN_WIDTH - 1);
			end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
				last_col_q <= MAX_LAST;
			end else begin
				last_col_q <= COL_W'(width_ext - CMP_W'(1));
			end
		end
	end

	assign accept   = pix_valid && !pix_stall;
	assign cc       = frame_start ? '0 : column_count_q;
	assign rc       = frame_start ? 2'd0 : row_count_q;
	assign col      = (cc > last_col_q) ? last_col_q : cc;
	assign row_done = (col == last_col_q);
	assign produce  = (rc >= ROW_FULL) && (col >= COL_W'(FIRST_COL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= 2'd0;
		end else if (accept) begin
			if (row_done) begin
				column_count_q <= '0;
				row_count_q    <= (rc >= ROW_FULL) ? ROW_FULL : rc + 2'd1;
			end else begin
				column_count_q <= col + COL_W'(1);
				row_count_q    <= rc;
			end
		end
	end

	assign out_free  = !res_valid_q || !res_stall;
	assign retire_s1 = valid_s1 && (!produce_s1 || out_free);
	assign pix_stall = valid_s1 && !retire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (retire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1      <= pixel;
			col_s1     <= col;
			produce_s1 <= produce;
			row_end_s1 <= row_done;
		end
	end

	assign lb_ctl.rd_en = accept;
	assign lb_ctl.wr_en = retire_s1;
	assign lb_wr.top    = lb_rd.mid;
	assign lb_wr.mid    = px_s1;

	lapedge_linebuf #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W)
	) u_linebuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (lb_ctl),
		.rd_addr (col),
		.wr_addr (col_s1),
		.wr_data (lb_wr),
		.rd_data (lb_rd)
	);

	// window: 0..2 column c-2, 3..5 column c-1, each top, middle, bottom
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (retire_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= lb_rd.top;
			win_q[4] <= lb_rd.mid;
			win_q[5] <= px_s1;
		end
	end

	// eight times the centre less the eight neighbours
	assign nb_sum = 11'(win_q[0]) + 11'(win_q[1]) + 11'(win_q[2]) + 11'(win_q[3])
		+ 11'(win_q[5]) + 11'(lb_rd.top) + 11'(lb_rd.mid) + 11'(px_s1);
	assign centre8 = {win_q[4], 3'b000};
	assign diff    = $signed({1'b0, centre8}) - $signed({1'b0, nb_sum});

	always_comb begin
		if (diff < 12'sd0) begin
			clamped = '0;
		end else if (diff > 12'(PIX_MAX)) begin
			clamped = PIX_W'(PIX_MAX);
		end else begin
			clamped = diff[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (retire_s1 && produce_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire_s1 && produce_s1) begin
			edge_value_q <= clamped;
			row_end_q    <= row_end_s1;
		end
	end

	assign res_valid  = res_valid_q;
	assign edge_value = edge_value_q;
	assign row_end    = row_end_q;

endmodule

>>> hw/rtl/lapedge_chk.sv
// port checker for the laplacian edge filter and its bind
`include "laplacian_edge_stencil_3x3_macros.svh"

module lapedge_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              pix_valid,
	input logic              pix_stall,
	input logic              res_valid,
	input logic              res_stall,
	input lapedge_pkg::pix_t edge_value,
	input logic              row_end
);
	import lapedge_pkg::*;

	// a stalled result keeps its value
	`LES_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(edge_value) && $stable(row_end), "result changed while stalled")

	// the input only waits behind a result that cannot leave
	`LES_ASSERT_IMPL(a_stall_cause, clk, arst_n, pix_stall, res_valid && res_stall, "input stalled without a blocked result")

	// a fresh result comes from an earlier pixel transfer through stage 1 and the output register
	`LES_ASSERT_IMPL(a_res_source, clk, arst_n, $rose(res_valid), $past(pix_valid && !pix_stall, 2), "result without a pixel transfer")

endmodule

bind laplacian_edge_stencil_3x3 lapedge_chk u_lapedge_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_valid  (pix_valid),
	.pix_stall  (pix_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.edge_value (edge_value),
	.row_end    (row_end)
);
